// ===== design/archive_record_deframer_assert.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef ARCHIVE_RECORD_DEFRAMER_ASSERT_SVH
`define ARCHIVE_RECORD_DEFRAMER_ASSERT_SVH

// Check an invariant at every clock edge outside reset.
`define ARD_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("deframer invariant violated");

// Check that a condition in one cycle implies another in the next cycle.
`define ARD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer sequence violated");

`endif

// ===== design/ard_pkg.sv =====
// Types and codes shared by the archive record deframer and its channels.
package ard_pkg;

	// One input transfer: a byte of the data section and the end-of-stream flag.
	typedef struct packed {
		logic [7:0] byte_value;
		logic       stream_end;
	} in_item_t;

	// One result transfer.
	typedef struct packed {
		logic [2:0]  kind;
		logic [30:0] value;
		logic        field_last;
		logic        run_last;
	} out_item_t;

	// Result kinds.
	localparam logic [2:0] KIND_NAME_HDR  = 3'd0;
	localparam logic [2:0] KIND_NAME_BYTE = 3'd1;
	localparam logic [2:0] KIND_DATA_HDR  = 3'd2;
	localparam logic [2:0] KIND_DATA_BYTE = 3'd3;
	localparam logic [2:0] KIND_END_OK    = 3'd4;
	localparam logic [2:0] KIND_END_TRUNC = 3'd5;

endpackage

// ===== design/ard_stream_if.sv =====
// Valid/ready channel carrying one payload item per transfer.
interface ard_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/archive_record_deframer.sv =====
// Archive record deframer: splits a byte stream into name/data headers and payload bytes.
// The block takes one byte of an archive data section per transfer on "bytes" and emits
// results on "results": a header carrying the field length when a 4-byte little-endian
// length word completes, one result per name or data byte (field_last on the final one),
// and, on the byte flagged stream_end, an end result that is ok only when that byte closes
// a record. Bit 31 of a length word requests 0..3 padding bytes that are skipped
// unchecked; lengths wider than LENGTH_BITS saturate to all ones. A byte is taken every
// cycle as long as results drain at one per cycle; a byte that yields two results (a
// header or payload byte plus the end result) fills two queue entries. The rate is set
// by the four-entry result queue: input is ready whenever at least two entries are free,
// and results are registered in the queue before they appear. run_last marks the last
// result caused by a byte. After the end result all parsing state returns to reset.
`include "archive_record_deframer_assert.svh"

module archive_record_deframer #(
	parameter int LENGTH_BITS = 31
) (
	input logic          clk,
	input logic          arst_n,
	ard_stream_if.sink   bytes,
	ard_stream_if.source results
);
	import ard_pkg::*;

	// Parser phases.
	localparam logic [2:0] PH_NAME_LEN   = 3'd0;
	localparam logic [2:0] PH_NAME_BYTES = 3'd1;
	localparam logic [2:0] PH_NAME_PAD   = 3'd2;
	localparam logic [2:0] PH_DATA_LEN   = 3'd3;
	localparam logic [2:0] PH_DATA_BYTES = 3'd4;
	localparam logic [2:0] PH_DATA_PAD   = 3'd5;

	localparam logic [LENGTH_BITS-1:0] REM_ONE = LENGTH_BITS'(1);

	// Result queue geometry.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam logic [Q_AW:0] Q_ROOM2 = (Q_AW + 1)'(Q_DEPTH - 2);

	// Parser state.
	logic [2:0]             phase_q;
	logic [1:0]             len_cnt_q;
	logic [23:0]            len_acc_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [1:0]             pad_q;

	logic [2:0]             phase_d;
	logic [1:0]             len_cnt_d;
	logic [23:0]            len_acc_d;
	logic [LENGTH_BITS-1:0] rem_d;
	logic [1:0]             pad_d;

	// Result queue.
	out_item_t       queue_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	in_item_t               item;
	logic                   take;
	logic                   pop;
	logic [2:0]             ph;
	logic                   is_data;
	logic [2:0]             after_field;
	logic [30:0]            len_raw;
	logic                   len_sat;
	logic [LENGTH_BITS-1:0] len_val;
	logic [30:0]            len_ext;
	logic                   last_byte;
	logic                   has_a;
	logic                   has_e;
	out_item_t              res_a;
	out_item_t              res_e;
	out_item_t              push0;
	logic [1:0]             n_push;

	assign item = bytes.payload;

	// Accept a byte whenever the queue can absorb the two results it may cause.
	assign bytes.ready   = (count_q <= Q_ROOM2);
	assign take          = bytes.valid && bytes.ready;
	assign results.valid = (count_q != '0);
	assign results.payload = queue_q[rd_ptr_q];
	assign pop           = results.valid && results.ready;

	// Assemble the length word: the fourth byte completes it without a register stage.
	assign len_raw = {item.byte_value[6:0], len_acc_q};
	assign len_sat = ((len_raw >> LENGTH_BITS) != '0);
	assign len_val = len_sat ? '1 : len_raw[LENGTH_BITS-1:0];

	always_comb begin
		len_ext = '0;
		len_ext[LENGTH_BITS-1:0] = len_val;
	end

	// Single-pass parser step for the byte at the input.
	always_comb begin
		ph = phase_q;
		if (ph > PH_DATA_PAD) begin
			ph = PH_NAME_LEN;
		end
		is_data     = (ph == PH_DATA_LEN) || (ph == PH_DATA_BYTES) || (ph == PH_DATA_PAD);
		after_field = is_data ? PH_NAME_LEN : PH_DATA_LEN;
		last_byte   = (rem_q <= REM_ONE);

		phase_d   = ph;
		len_cnt_d = len_cnt_q;
		len_acc_d = len_acc_q;
		rem_d     = rem_q;
		pad_d     = pad_q;
		has_a     = 1'b0;
		res_a     = '0;

		case (ph)
			PH_NAME_LEN, PH_DATA_LEN: begin
				if (len_cnt_q != 2'd3) begin
					len_acc_d = len_acc_q | (24'(item.byte_value) << {len_cnt_q, 3'b000});
					len_cnt_d = len_cnt_q + 2'd1;
				end else begin
					// Length word complete: emit the header and set up the field.
					has_a       = 1'b1;
					res_a.kind  = is_data ? KIND_DATA_HDR : KIND_NAME_HDR;
					res_a.value = len_ext;
					len_cnt_d   = '0;
					len_acc_d   = '0;
					rem_d       = len_val;
					pad_d       = item.byte_value[7] ? (2'd0 - len_val[1:0]) : 2'd0;
					if (len_val != '0) begin
						phase_d = is_data ? PH_DATA_BYTES : PH_NAME_BYTES;
					end else begin
						phase_d = after_field;
					end
				end
			end
			PH_NAME_BYTES, PH_DATA_BYTES: begin
				has_a            = 1'b1;
				res_a.kind       = is_data ? KIND_DATA_BYTE : KIND_NAME_BYTE;
				res_a.value      = 31'(item.byte_value);
				res_a.field_last = last_byte;
				rem_d            = last_byte ? '0 : rem_q - REM_ONE;
				if (last_byte) begin
					if (pad_q != 2'd0) begin
						phase_d = is_data ? PH_DATA_PAD : PH_NAME_PAD;
					end else begin
						phase_d = after_field;
					end
				end
			end
			default: begin
				// Padding: skip the byte without looking at it.
				if (pad_q <= 2'd1) begin
					pad_d   = 2'd0;
					phase_d = after_field;
				end else begin
					pad_d = pad_q - 2'd1;
				end
			end
		endcase

		// End of stream: report status and drop back to reset state.
		has_e = item.stream_end;
		res_e = '0;
		res_e.kind = ((phase_d == PH_NAME_LEN) && (len_cnt_d == 2'd0)) ?
			KIND_END_OK : KIND_END_TRUNC;
		res_e.run_last = 1'b1;
		if (item.stream_end) begin
			phase_d   = PH_NAME_LEN;
			len_cnt_d = '0;
			len_acc_d = '0;
			rem_d     = '0;
			pad_d     = '0;
		end

		res_a.run_last = !has_e;
		push0  = has_a ? res_a : res_e;
		n_push = take ? ({1'b0, has_a} + {1'b0, has_e}) : 2'd0;
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_NAME_LEN;
			len_cnt_q <= '0;
			len_acc_q <= '0;
			rem_q     <= '0;
			pad_q     <= '0;
		end else if (take) begin
			phase_q   <= phase_d;
			len_cnt_q <= len_cnt_d;
			len_acc_q <= len_acc_d;
			rem_q     <= rem_d;
			pad_q     <= pad_d;
		end
	end

	// Queue storage: write up to two results per transfer.
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= push0;
		end
		if (n_push == 2'd2) begin
			queue_q[wr_ptr_q + Q_AW'(1)] <= res_e;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_AW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			count_q <= count_q + (Q_AW + 1)'(n_push) - (Q_AW + 1)'(pop);
		end
	end

	`ARD_ASSERT_ALWAYS(a_queue_bound, count_q <= (Q_AW + 1)'(Q_DEPTH))
	`ARD_ASSERT_ALWAYS(a_phase_legal, phase_q <= PH_DATA_PAD)
	`ARD_ASSERT_ALWAYS(a_bytes_pending,
		((phase_q != PH_NAME_BYTES) && (phase_q != PH_DATA_BYTES)) || (rem_q != '0))
	`ARD_ASSERT_NEXT(a_end_resets, take && item.stream_end,
		(phase_q == PH_NAME_LEN) && (len_cnt_q == 2'd0) && (count_q != '0))

endmodule
